// ===== sv/i2cram_pkg.sv =====
// Package with the phase and byte role types and the register offsets of the I2C register access master.
package i2cram_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAIT_FREE, PH_START, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_LOW,
    PH_ACK_HIGH, PH_RS_LOW, PH_RS_HIGH, PH_STOP_LOW, PH_STOP_HIGH,
    PH_STOP_END, PH_REC_REL, PH_REC_LOW, PH_REC_HIGH
  } phase_t;

  typedef enum logic [2:0] {
    RL_ADDR_W, RL_REG, RL_ADDR_R, RL_WDATA, RL_RDATA
  } role_t;

  localparam logic [1:0] REG_SCL_LOW  = 2'd0;
  localparam logic [1:0] REG_SCL_HIGH = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

endpackage

// ===== sv/i2c_register_access_master_core.sv =====
// Top level of the I2C register access master with bus recovery.
// Each request is one system clock tick carrying the sampled SDA and SCL lines; one request
// is taken every cycle unless a low out_ready holds out_valid; its result is registered for
// the next cycle, so a transaction runs over as many ticks as its bit timing asks. SCL low and
// high time come from scl_low_ticks and scl_high_ticks; waits for a free bus or a stretched
// clock fail at timeout_limit; a bus failure sends up to RECOVERY_PULSES pulses, then a STOP.
module i2c_register_access_master_core #(
  parameter int MAX_LENGTH      = 255,
  parameter int RECOVERY_PULSES = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic        is_read,
  input  logic [6:0]  dev_addr,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  length,
  input  logic [7:0]  write_byte,
  input  logic        sda_in,
  input  logic        scl_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_out,
  output logic        sda_out,
  output logic        byte_taken,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic        read_last,
  output logic        done_res,
  output logic        error,
  output logic        busy_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] scl_low_ticks, scl_high_ticks;
  logic [23:0] timeout_limit;
  logic [1:0]  reg_idx;
  logic        reg_ok;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_ok  = (paddr[1:0] == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_low_ticks  <= 12'd77;
      scl_high_ticks <= 12'd43;
      timeout_limit  <= 24'd65535;
    end else if (psel && penable && pwrite && reg_ok) begin
      case (reg_idx)
        i2cram_pkg::REG_SCL_LOW:  scl_low_ticks  <= pwdata[11:0];
        i2cram_pkg::REG_SCL_HIGH: scl_high_ticks <= pwdata[11:0];
        i2cram_pkg::REG_TIMEOUT:  timeout_limit  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_ok) begin
      case (reg_idx)
        i2cram_pkg::REG_SCL_LOW:  prdata = {20'd0, scl_low_ticks};
        i2cram_pkg::REG_SCL_HIGH: prdata = {20'd0, scl_high_ticks};
        i2cram_pkg::REG_TIMEOUT:  prdata = {8'd0, timeout_limit};
        default: prdata = 32'd0;
      endcase
    end
  end

  logic [11:0] low_lim, high_lim;
  logic [23:0] to_lim;
  assign low_lim  = (scl_low_ticks == 12'd0) ? 12'd1 : scl_low_ticks;
  assign high_lim = (scl_high_ticks == 12'd0) ? 12'd1 : scl_high_ticks;
  assign to_lim   = (timeout_limit == 24'd0) ? 24'd1 : timeout_limit;

  i2cram_pkg::phase_t phase, phase_next;
  i2cram_pkg::role_t  role, role_next;
  logic [3:0]  bit_index, bit_index_next, pulse_count, pulse_count_next;
  logic [7:0]  bytes_left, bytes_left_next, shift_reg, shift_reg_next;
  logic [11:0] phase_timer, phase_timer_next;
  logic [23:0] wait_counter, wait_counter_next;
  logic [6:0]  saved_dev_addr, saved_dev_addr_next;
  logic [7:0]  saved_reg_addr, saved_reg_addr_next;
  logic        saved_is_read, saved_is_read_next, error_seen, error_seen_next;
  logic        scl_drv, scl_drv_next, sda_drv, sda_drv_next;
  logic        ev_taken, ev_rvalid, ev_rlast, ev_done, ev_err;

  logic        step;
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_comb begin
    logic        tx, low_done, hi_done, hi_to, do_fail, go;
    logic [11:0] pt_inc;
    logic [23:0] wc_inc;
    i2cram_pkg::phase_t ent;
    logic [2:0]  bsel;

    phase_next = phase; role_next = role; bit_index_next = bit_index;
    pulse_count_next = pulse_count; bytes_left_next = bytes_left;
    shift_reg_next = shift_reg; phase_timer_next = phase_timer;
    wait_counter_next = wait_counter; saved_dev_addr_next = saved_dev_addr;
    saved_reg_addr_next = saved_reg_addr; saved_is_read_next = saved_is_read;
    error_seen_next = error_seen; scl_drv_next = scl_drv; sda_drv_next = sda_drv;
    ev_taken = 1'b0; ev_rvalid = 1'b0; ev_rlast = 1'b0; ev_done = 1'b0; ev_err = 1'b0;
    tx = (role != i2cram_pkg::RL_RDATA);
    pt_inc = phase_timer + 12'd1;
    wc_inc = wait_counter + 24'd1;
    low_done = (pt_inc == 12'd0) || (pt_inc >= low_lim);
    hi_done  = (pt_inc == 12'd0) || (pt_inc >= high_lim);
    hi_to    = (wc_inc == 24'd0) || (wc_inc >= to_lim);
    do_fail = 1'b0; go = 1'b0; ent = phase;
    bsel = 3'd7 - bit_index[2:0];

    case (phase)
      i2cram_pkg::PH_WAIT_FREE: begin
        if (sda_in && scl_in) begin go = 1'b1; ent = i2cram_pkg::PH_START; end
        else begin wait_counter_next = wc_inc; do_fail = hi_to; end
      end
      i2cram_pkg::PH_START, i2cram_pkg::PH_RS_HIGH, i2cram_pkg::PH_ACK_HIGH,
      i2cram_pkg::PH_BIT_HIGH, i2cram_pkg::PH_STOP_HIGH: begin
        if (phase == i2cram_pkg::PH_BIT_HIGH && tx && sda_drv && scl_in && !sda_in) begin
          do_fail = 1'b1;
        end else if (!scl_in && !(phase == i2cram_pkg::PH_STOP_HIGH && error_seen)) begin
          wait_counter_next = wc_inc; do_fail = hi_to;
        end else begin
          phase_timer_next = pt_inc;
          if (hi_done) begin
            go = 1'b1;
            case (phase)
              i2cram_pkg::PH_START: begin
                bit_index_next = 4'd0; ent = i2cram_pkg::PH_BIT_LOW;
              end
              i2cram_pkg::PH_RS_HIGH: begin
                role_next = i2cram_pkg::RL_ADDR_R;
                shift_reg_next = {saved_dev_addr, 1'b1};
                ent = i2cram_pkg::PH_START;
              end
              i2cram_pkg::PH_STOP_HIGH: ent = i2cram_pkg::PH_STOP_END;
              i2cram_pkg::PH_BIT_HIGH: begin
                if (!tx) shift_reg_next = {shift_reg[6:0], sda_in};
                bit_index_next = bit_index + 4'd1;
                if (bit_index_next >= 4'd8) begin
                  if (!tx) begin ev_rvalid = 1'b1; ev_rlast = (bytes_left == 8'd1); end
                  ent = i2cram_pkg::PH_ACK_LOW;
                end else ent = i2cram_pkg::PH_BIT_LOW;
              end
              default: begin
                if (tx && sda_in) begin go = 1'b0; do_fail = 1'b1; end
                else begin
                  ent = i2cram_pkg::PH_BIT_LOW; bit_index_next = 4'd0;
                  case (role)
                    i2cram_pkg::RL_ADDR_W: begin
                      role_next = i2cram_pkg::RL_REG; shift_reg_next = saved_reg_addr;
                    end
                    i2cram_pkg::RL_REG: begin
                      if (saved_is_read) begin
                        ent = i2cram_pkg::PH_RS_LOW; bit_index_next = bit_index;
                      end else begin
                        role_next = i2cram_pkg::RL_WDATA; shift_reg_next = write_byte;
                        ev_taken = 1'b1;
                      end
                    end
                    i2cram_pkg::RL_ADDR_R: begin
                      role_next = i2cram_pkg::RL_RDATA; shift_reg_next = 8'd0;
                    end
                    default: begin
                      bytes_left_next = bytes_left - 8'd1;
                      if (bytes_left_next == 8'd0) begin
                        ent = i2cram_pkg::PH_STOP_LOW; bit_index_next = bit_index;
                      end else if (role == i2cram_pkg::RL_WDATA) begin
                        shift_reg_next = write_byte; ev_taken = 1'b1;
                      end
                    end
                  endcase
                end
              end
            endcase
          end
        end
      end
      i2cram_pkg::PH_BIT_LOW, i2cram_pkg::PH_ACK_LOW, i2cram_pkg::PH_RS_LOW,
      i2cram_pkg::PH_STOP_LOW, i2cram_pkg::PH_REC_LOW: begin
        if (phase_timer == 12'd0) begin
          case (phase)
            i2cram_pkg::PH_BIT_LOW:
              sda_drv_next = (role == i2cram_pkg::RL_RDATA) ? 1'b1 : shift_reg[bsel];
            i2cram_pkg::PH_ACK_LOW:
              sda_drv_next = !(role == i2cram_pkg::RL_RDATA && bytes_left > 8'd1);
            i2cram_pkg::PH_STOP_LOW: sda_drv_next = 1'b0;
            default: sda_drv_next = 1'b1;
          endcase
        end
        phase_timer_next = pt_inc;
        if (low_done) begin
          go = 1'b1;
          case (phase)
            i2cram_pkg::PH_BIT_LOW:  ent = i2cram_pkg::PH_BIT_HIGH;
            i2cram_pkg::PH_ACK_LOW:  ent = i2cram_pkg::PH_ACK_HIGH;
            i2cram_pkg::PH_RS_LOW:   ent = i2cram_pkg::PH_RS_HIGH;
            i2cram_pkg::PH_STOP_LOW: ent = i2cram_pkg::PH_STOP_HIGH;
            default:                 ent = i2cram_pkg::PH_REC_HIGH;
          endcase
        end
      end
      i2cram_pkg::PH_STOP_END: begin
        phase_timer_next = pt_inc;
        if (hi_done) begin
          ev_done = 1'b1; ev_err = error_seen; error_seen_next = 1'b0;
          go = 1'b1; ent = i2cram_pkg::PH_IDLE;
        end
      end
      i2cram_pkg::PH_REC_REL, i2cram_pkg::PH_REC_HIGH: begin
        phase_timer_next = pt_inc;
        if (hi_done) begin
          go = 1'b1;
          if ({28'd0, pulse_count} < RECOVERY_PULSES && !sda_in) begin
            pulse_count_next = pulse_count + 4'd1; ent = i2cram_pkg::PH_REC_LOW;
          end else ent = i2cram_pkg::PH_STOP_LOW;
        end
      end
      default: begin
        if (kind) begin
          if (length == 8'd0 || {24'd0, length} > MAX_LENGTH) begin
            ev_done = 1'b1; ev_err = 1'b1;
          end else begin
            saved_is_read_next = is_read; saved_dev_addr_next = dev_addr;
            saved_reg_addr_next = reg_addr; bytes_left_next = length;
            role_next = i2cram_pkg::RL_ADDR_W; shift_reg_next = {dev_addr, 1'b0};
            error_seen_next = 1'b0; go = 1'b1; ent = i2cram_pkg::PH_WAIT_FREE;
          end
        end
      end
    endcase

    if (do_fail) begin
      error_seen_next = 1'b1; pulse_count_next = 4'd0;
      go = 1'b1; ent = i2cram_pkg::PH_REC_REL;
    end
    if (go) begin
      phase_next = ent; phase_timer_next = 12'd0; wait_counter_next = 24'd0;
      case (ent)
        i2cram_pkg::PH_IDLE, i2cram_pkg::PH_WAIT_FREE, i2cram_pkg::PH_REC_REL,
        i2cram_pkg::PH_STOP_END: begin scl_drv_next = 1'b1; sda_drv_next = 1'b1; end
        i2cram_pkg::PH_START: begin scl_drv_next = 1'b1; sda_drv_next = 1'b0; end
        i2cram_pkg::PH_BIT_LOW, i2cram_pkg::PH_ACK_LOW, i2cram_pkg::PH_RS_LOW,
        i2cram_pkg::PH_STOP_LOW, i2cram_pkg::PH_REC_LOW: scl_drv_next = 1'b0;
        default: scl_drv_next = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2cram_pkg::PH_IDLE; role <= i2cram_pkg::RL_ADDR_W;
      bit_index <= 4'd0; pulse_count <= 4'd0; bytes_left <= 8'd0; shift_reg <= 8'd0;
      phase_timer <= 12'd0; wait_counter <= 24'd0; saved_dev_addr <= 7'd0;
      saved_reg_addr <= 8'd0; saved_is_read <= 1'b0; error_seen <= 1'b0;
      scl_drv <= 1'b1; sda_drv <= 1'b1; out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (step) begin
        phase <= phase_next; role <= role_next; bit_index <= bit_index_next;
        pulse_count <= pulse_count_next; bytes_left <= bytes_left_next;
        shift_reg <= shift_reg_next; phase_timer <= phase_timer_next;
        wait_counter <= wait_counter_next; saved_dev_addr <= saved_dev_addr_next;
        saved_reg_addr <= saved_reg_addr_next; saved_is_read <= saved_is_read_next;
        error_seen <= error_seen_next; scl_drv <= scl_drv_next; sda_drv <= sda_drv_next;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      scl_out <= scl_drv_next; sda_out <= sda_drv_next; byte_taken <= ev_taken;
      read_byte <= ev_rvalid ? shift_reg_next : 8'd0;
      read_valid <= ev_rvalid; read_last <= ev_rlast; done_res <= ev_done;
      error <= ev_err; busy_res <= (phase_next != i2cram_pkg::PH_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    step |=> busy_res == (phase != i2cram_pkg::PH_IDLE)) else $error("busy mismatch");
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> done_res) else $error("error without done");
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_last |-> read_valid) else $error("last without valid");
  a_pulses: assert property (@(posedge clk) disable iff (rst)
    {28'd0, pulse_count} <= RECOVERY_PULSES) else $error("too many recovery pulses");
`endif

endmodule
